@@ src/urs_pkg.sv @@
// Shared types, constants and helpers for the ultrasonic ranging sequencer.
package urs_pkg;

	// Sensor count and field widths
	localparam int unsigned NUM_SENSORS = 3;
	localparam int unsigned RANGE_COUNT = 3;
	localparam int unsigned IDX_W       = 2;
	localparam int unsigned ECHO_W      = 3;
	localparam int unsigned TRIG_W      = 10;
	localparam int unsigned GAP_W       = 20;
	localparam int unsigned TMO_W       = 16;
	localparam int unsigned START_W     = 22;
	localparam int unsigned CNT_W       = 22;
	localparam int unsigned WIDTH_W     = 16;
	localparam int unsigned RANGE_W     = 14;
	localparam int unsigned CFG_IDX_W   = 8;
	localparam int unsigned CFG_DATA_W  = 22;

	// Register reset values
	localparam logic [TRIG_W-1:0]  TRIG_RESET  = 10'd10;
	localparam logic [GAP_W-1:0]   GAP_RESET   = 20'd100000;
	localparam logic [TMO_W-1:0]   TMO_RESET   = 16'd30000;
	localparam logic [START_W-1:0] START_RESET = 22'd2000000;

	// Distance = floor(width * 172 / 1000) = floor(width * 43 / 250),
	// done as a multiply by a rounded-up reciprocal and a shift. Exact for
	// every 16-bit width since width * (mul * 250 - 43 * 2^24) < 2^24.
	localparam int unsigned RANGE_SHIFT = 24;
	localparam int unsigned MUL_W       = 22;
	localparam int unsigned PROD_W      = WIDTH_W + MUL_W;
	localparam logic [MUL_W-1:0] RANGE_MUL = 22'd2885682;

	typedef enum logic [2:0] {
		PH_STARTUP = 3'd0,
		PH_TRIGGER = 3'd1,
		PH_RISE    = 3'd2,
		PH_HIGH    = 3'd3,
		PH_GAP     = 3'd4
	} phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TRIGGER_WIDTH = 8'd0,
		REG_GAP_TICKS     = 8'd1,
		REG_TIMEOUT_TICKS = 8'd2,
		REG_STARTUP_TICKS = 8'd3
	} cfg_reg_t;

	function automatic logic [RANGE_W-1:0] width_to_range(input logic [WIDTH_W-1:0] w);
		logic [PROD_W-1:0] prod;
		prod = PROD_W'(w) * PROD_W'(RANGE_MUL);
		return prod[RANGE_SHIFT +: RANGE_W];
	endfunction

endpackage

@@ src/urs_if.sv @@
// Valid/ready channel interfaces: tick input, result output, register writes.
interface urs_tick_if;
	logic                            valid;
	logic                            ready;
	logic [urs_pkg::ECHO_W-1:0]      echo_levels;
	logic                            run_enable;

	modport source(output valid, echo_levels, run_enable, input ready);
	modport sink(input valid, echo_levels, run_enable, output ready);
endinterface

interface urs_result_if;
	logic                            valid;
	logic                            ready;
	logic [urs_pkg::ECHO_W-1:0]      trigger_lines;
	logic                            result_valid;
	logic [urs_pkg::IDX_W-1:0]       result_sensor;
	logic                            timed_out;
	logic [urs_pkg::RANGE_W-1:0]     range_0;
	logic [urs_pkg::RANGE_W-1:0]     range_1;
	logic [urs_pkg::RANGE_W-1:0]     range_2;

	modport source(output valid, trigger_lines, result_valid, result_sensor, timed_out,
		range_0, range_1, range_2, input ready);
	modport sink(input valid, trigger_lines, result_valid, result_sensor, timed_out,
		range_0, range_1, range_2, output ready);
endinterface

interface urs_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [urs_pkg::CFG_IDX_W-1:0]   index;
	logic [urs_pkg::CFG_DATA_W-1:0]  data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

@@ src/ultrasonic_ranging_sequencer.sv @@
// Top level: tick-driven trigger/echo sequencer for three ultrasonic rangers.
//
// Usage:
//   tick   : one word per microsecond tick, carrying echo_levels and run_enable.
//   result : exactly one word per tick word: trigger drive, end-of-measurement
//            flags and the three stored distances (tenths of a cm, including
//            any update made by that tick).
//   cfg    : register writes (0 trigger_width, 1 gap_ticks, 2 timeout_ticks,
//            3 startup_ticks); always ready, other indexes are dropped. Write
//            only while no tick word is in flight.
// Timing: a tick word sits in an input register, one pass of logic computes
//   the next sequencer state and the result word into the output register.
//   One word per cycle is taken as long as the result side keeps up.
// Stall: when result.ready is low, the result word holds and the input
//   register fills; tick.ready drops once both are full.
// Reset: registers return to their defaults, sequencer goes to the start-up
//   wait with sensor 0 next, stored distances clear to zero, both stages empty.
module ultrasonic_ranging_sequencer (
	input  logic          clk,
	input  logic          arst_n,
	urs_tick_if.sink      tick,
	urs_result_if.source  result,
	urs_cfg_if.sink       cfg
);

	// Configuration registers
	logic [urs_pkg::TRIG_W-1:0]  trig_width_q;
	logic [urs_pkg::GAP_W-1:0]   gap_ticks_q;
	logic [urs_pkg::TMO_W-1:0]   timeout_q;
	logic [urs_pkg::START_W-1:0] startup_q;

	// Input stage
	logic                        tick_valid_s1;
	logic [urs_pkg::ECHO_W-1:0]  echo_s1;
	logic                        run_s1;

	// Sequencer state
	urs_pkg::phase_t             phase_q, phase_d;
	logic [urs_pkg::IDX_W-1:0]   idx_q, idx_d;
	logic [urs_pkg::CNT_W-1:0]   cnt_q, cnt_d;
	logic [urs_pkg::WIDTH_W-1:0] width_q, width_d;
	logic [urs_pkg::RANGE_W-1:0] ranges_q [urs_pkg::RANGE_COUNT];
	logic [urs_pkg::RANGE_W-1:0] ranges_d [urs_pkg::RANGE_COUNT];

	// Output stage
	logic                        out_valid_s2;
	logic [urs_pkg::ECHO_W-1:0]  trig_s2;
	logic                        res_valid_s2;
	logic [urs_pkg::IDX_W-1:0]   res_sensor_s2;
	logic                        tout_s2;
	logic [urs_pkg::RANGE_W-1:0] range_s2 [urs_pkg::RANGE_COUNT];

	// Step logic
	logic                        advance;
	logic [urs_pkg::CNT_W-1:0]   cnt_inc;
	logic [urs_pkg::WIDTH_W-1:0] width_inc;
	logic [urs_pkg::ECHO_W:0]    echo_ext;
	logic [urs_pkg::ECHO_W:0]    trig_dec;
	logic                        echo_high;
	logic [urs_pkg::ECHO_W-1:0]  trig_c;
	logic                        ended_c;
	logic                        failed_c;
	logic [urs_pkg::RANGE_W-1:0] range_new;
	logic [urs_pkg::IDX_W:0]     idx_inc;

	// Handshakes
	assign advance    = tick_valid_s1 && (!out_valid_s2 || result.ready);
	assign tick.ready = !tick_valid_s1 || advance;
	assign cfg.ready  = 1'b1;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_width_q <= urs_pkg::TRIG_RESET;
			gap_ticks_q  <= urs_pkg::GAP_RESET;
			timeout_q    <= urs_pkg::TMO_RESET;
			startup_q    <= urs_pkg::START_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				urs_pkg::REG_TRIGGER_WIDTH: trig_width_q <= cfg.data[urs_pkg::TRIG_W-1:0];
				urs_pkg::REG_GAP_TICKS:     gap_ticks_q  <= cfg.data[urs_pkg::GAP_W-1:0];
				urs_pkg::REG_TIMEOUT_TICKS: timeout_q    <= cfg.data[urs_pkg::TMO_W-1:0];
				urs_pkg::REG_STARTUP_TICKS: startup_q    <= cfg.data[urs_pkg::START_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			tick_valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			echo_s1 <= tick.echo_levels;
			run_s1  <= tick.run_enable;
		end
	end

	// Shared terms
	assign cnt_inc   = cnt_q + urs_pkg::CNT_W'(1);
	assign width_inc = width_q + urs_pkg::WIDTH_W'(1);
	assign echo_ext  = {1'b0, echo_s1};
	assign echo_high = echo_ext[idx_q];
	assign trig_dec  = (urs_pkg::ECHO_W+1)'(1) << idx_q;
	assign range_new = urs_pkg::width_to_range(width_q);
	assign idx_inc   = {1'b0, idx_q} + (urs_pkg::IDX_W+1)'(1);

	// Outputs of the step: trigger drive and measurement end
	always_comb begin
		trig_c   = '0;
		ended_c  = 1'b0;
		failed_c = 1'b0;
		if (run_s1) begin
			case (phase_q)
				urs_pkg::PH_TRIGGER: begin
					trig_c = trig_dec[urs_pkg::ECHO_W-1:0];
				end
				urs_pkg::PH_RISE: begin
					if (echo_high) begin
						if (urs_pkg::TMO_W'(1) >= timeout_q) begin
							ended_c  = 1'b1;
							failed_c = 1'b1;
						end
					end else if (cnt_inc >= urs_pkg::CNT_W'(timeout_q)) begin
						ended_c  = 1'b1;
						failed_c = 1'b1;
					end
				end
				urs_pkg::PH_HIGH: begin
					if (echo_high) begin
						if (width_inc >= timeout_q) begin
							ended_c  = 1'b1;
							failed_c = 1'b1;
						end
					end else begin
						ended_c = 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Next state of the sequencer
	always_comb begin
		phase_d = phase_q;
		idx_d   = idx_q;
		cnt_d   = cnt_q;
		width_d = width_q;
		if (!run_s1) begin
			phase_d = urs_pkg::PH_STARTUP;
			idx_d   = '0;
			cnt_d   = '0;
			width_d = '0;
		end else begin
			case (phase_q)
				urs_pkg::PH_STARTUP: begin
					cnt_d = cnt_inc;
					if (cnt_inc >= urs_pkg::CNT_W'(startup_q)) begin
						phase_d = urs_pkg::PH_TRIGGER;
						cnt_d   = '0;
					end
				end
				urs_pkg::PH_TRIGGER: begin
					cnt_d = cnt_inc;
					if (cnt_inc >= urs_pkg::CNT_W'(trig_width_q)) begin
						phase_d = urs_pkg::PH_RISE;
						cnt_d   = '0;
					end
				end
				urs_pkg::PH_RISE: begin
					if (echo_high) begin
						width_d = urs_pkg::WIDTH_W'(1);
						phase_d = urs_pkg::PH_HIGH;
					end else begin
						cnt_d = cnt_inc;
					end
				end
				urs_pkg::PH_HIGH: begin
					if (echo_high) width_d = width_inc;
				end
				urs_pkg::PH_GAP: begin
					cnt_d = cnt_inc;
					if (cnt_inc >= urs_pkg::CNT_W'(gap_ticks_q)) begin
						idx_d   = (idx_inc >= (urs_pkg::IDX_W+1)'(urs_pkg::NUM_SENSORS))
							? '0 : idx_inc[urs_pkg::IDX_W-1:0];
						phase_d = urs_pkg::PH_TRIGGER;
						cnt_d   = '0;
					end
				end
				default: begin
					phase_d = urs_pkg::PH_STARTUP;
					idx_d   = '0;
					cnt_d   = '0;
					width_d = '0;
				end
			endcase
			if (ended_c) begin
				phase_d = urs_pkg::PH_GAP;
				cnt_d   = '0;
				width_d = '0;
			end
		end
	end

	// Stored distance update on a good measurement
	always_comb begin
		for (int i = 0; i < urs_pkg::RANGE_COUNT; i++) begin
			ranges_d[i] = ranges_q[i];
			if (ended_c && !failed_c && idx_q == urs_pkg::IDX_W'(i)) ranges_d[i] = range_new;
		end
	end

	// State registers, advanced once per tick word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= urs_pkg::PH_STARTUP;
			idx_q   <= '0;
			cnt_q   <= '0;
			width_q <= '0;
			for (int i = 0; i < urs_pkg::RANGE_COUNT; i++) ranges_q[i] <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
			cnt_q   <= cnt_d;
			width_q <= width_d;
			for (int i = 0; i < urs_pkg::RANGE_COUNT; i++) ranges_q[i] <= ranges_d[i];
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (!out_valid_s2 || result.ready) begin
			out_valid_s2 <= tick_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			trig_s2       <= trig_c;
			res_valid_s2  <= ended_c;
			res_sensor_s2 <= ended_c ? idx_q : '0;
			tout_s2       <= failed_c;
			for (int i = 0; i < urs_pkg::RANGE_COUNT; i++) range_s2[i] <= ranges_d[i];
		end
	end

	assign result.valid         = out_valid_s2;
	assign result.trigger_lines = trig_s2;
	assign result.result_valid  = res_valid_s2;
	assign result.result_sensor = res_sensor_s2;
	assign result.timed_out     = tout_s2;
	assign result.range_0       = range_s2[0];
	assign result.range_1       = range_s2[1];
	assign result.range_2       = range_s2[2];

	// Checks
	a_width_only_high: assert property (@(posedge clk) disable iff (!arst_n)
		(width_q != '0) |-> (phase_q == urs_pkg::PH_HIGH))
		else $error("echo width held outside the high phase");

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q < urs_pkg::IDX_W'(urs_pkg::NUM_SENSORS))
		else $error("sensor index beyond sensor count");

	a_startup_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == urs_pkg::PH_STARTUP) |-> (idx_q == '0 && cnt_q <= urs_pkg::CNT_W'(startup_q)
			|| idx_q == '0))
		else $error("start-up wait with a sensor other than the first");

	a_no_trig_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_s2 && res_valid_s2) |-> (trig_s2 == '0))
		else $error("trigger driven on the tick a measurement ends");

	a_timeout_flags_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_s2 && tout_s2) |-> res_valid_s2)
		else $error("timeout flagged without an ended measurement");

endmodule
